// ===== rtl/tss_pkg.sv =====
package tss_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic        [31:0] time_us;
  } tss_in_t;

  typedef struct packed {
    logic signed [23:0] speed_mm_s;
    logic               window_full;
    logic               outlier_rejected;
    logic               bad_interval;
  } tss_out_t;

  localparam logic [1:0] REG_WEIGHT_CENTER = 2'd0;
  localparam logic [1:0] REG_WEIGHT_NEAR   = 2'd1;
  localparam logic [1:0] REG_WEIGHT_FAR    = 2'd2;
  localparam logic [1:0] REG_SPREAD_MULT   = 2'd3;

  localparam logic signed [23:0] SPD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPD_MIN = -24'sh800000;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  localparam logic        REQ_START  = 1'b0;
  localparam logic        REQ_UPDATE = 1'b1;

endpackage

// ===== rtl/track_speed_smoother_top.sv =====
// Speed smoother for one tracked object; one multiplier is shared by the weighted sum and the spread.
// Sequence: a start item or zero-interval update goes straight to the result;
// an update runs the square root, then the divide, and with a full window
// also 3 multiply steps, 4 sort passes, spread and judge.
// Throughput: one item at a time; in_stall is high until the result is taken.
// Reset (synchronous rst): config registers return to defaults, track state zero.
module track_speed_smoother_top
  import tss_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tss_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tss_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW = $clog2(WINDOW_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_DIV, S_MAG, S_MUL, S_SORT, S_SPREAD, S_JUDGE, S_OUT
  } state_t;

  state_t state;

  logic [15:0] weight_center, weight_near, weight_far;
  logic [9:0]  spread_mult;

  logic signed [19:0] last_x, last_y;
  logic [31:0] last_time;
  logic signed [23:0] speed_window [WINDOW_DEPTH];
  logic [CW-1:0] window_count;
  logic signed [23:0] held_speed;

  tss_in_t cur;
  logic signed [20:0] dx, dy;
  logic [31:0] dt;
  logic        neg;

  logic        sq_start, sq_done;
  logic [28:0] sq_root;
  logic [57:0] radicand;
  logic        dv_start, dv_done;
  logic [48:0] dv_q;
  logic [48:0] dividend;
  logic [39:0] divisor;

  logic signed [23:0] v;
  logic signed [23:0] mag_sat;
  logic [1:0]  step;
  logic signed [63:0] acc;
  logic signed [34:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [60:0] mul_p;
  logic signed [23:0] srt [WINDOW_DEPTH];
  logic [1:0]  sstep;
  logic signed [35:0] spread;
  logic signed [23:0] fval;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_center <= 16'd43504;
      weight_near   <= 16'd10848;
      weight_far    <= 16'd168;
      spread_mult   <= 10'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_CENTER: weight_center <= cfg_data;
        REG_WEIGHT_NEAR:   weight_near   <= cfg_data;
        REG_WEIGHT_FAR:    weight_far    <= cfg_data;
        REG_SPREAD_MULT:   spread_mult   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Squared distance in Q16
  logic [20:0] adx, ady;
  assign adx = dx[20] ? 21'(-dx) : 21'(dx);
  assign ady = dy[20] ? 21'(-dy) : 21'(dy);
  assign radicand = {42'(adx) * 42'(adx) + 42'(ady) * 42'(ady), 16'd0};

  tss_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(radicand),
    .done(sq_done), .root(sq_root)
  );

  assign dividend = 49'(sq_root) * 49'(USEC_PER_SEC) + 49'({dt, 7'd0});
  assign divisor  = {dt, 8'd0};

  tss_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dividend),
    .divisor(divisor), .done(dv_done), .quotient(dv_q)
  );

  // Saturate the magnitude and apply the sign of dx
  assign mag_sat = (dv_q > 49'(SPD_MAX)) ? SPD_MAX : $signed(dv_q[23:0]);
  assign v       = neg ? -mag_sat : mag_sat;

  // Shared multiplier
  assign mul_p = 61'(mul_a * mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      case (step)
        2'd0: begin mul_a = 35'(speed_window[0]); mul_b = 26'($signed({1'b0, weight_center})); end
        2'd1: begin mul_a = 35'(speed_window[1]); mul_b = 26'($signed({1'b0, weight_near})); end
        default: begin mul_a = 35'(speed_window[2]); mul_b = 26'($signed({1'b0, weight_far})); end
      endcase
    end else begin
      mul_a = 35'(srt[3*WINDOW_DEPTH/4]) - 35'(srt[WINDOW_DEPTH/4]);
      mul_b = 26'($signed({1'b0, spread_mult}));
    end
  end

  // Rounded Q16 sum with saturation
  logic signed [63:0] rnd;
  logic signed [47:0] fq;
  always_comb begin
    rnd = acc + 64'sd32768;
    fq  = 48'(rnd >>> 16);
    if (fq > 48'(SPD_MAX)) fval = SPD_MAX;
    else if (fq < 48'(SPD_MIN)) fval = SPD_MIN;
    else fval = fq[23:0];
  end

  // Bounds test in Q8
  logic signed [36:0] lo, hi, f8;
  logic               outl;
  assign lo   = 37'($signed({srt[WINDOW_DEPTH/4], 8'd0})) - 37'(spread);
  assign hi   = 37'($signed({srt[3*WINDOW_DEPTH/4], 8'd0})) + 37'(spread);
  assign f8   = 37'($signed({fval, 8'd0}));
  assign outl = (f8 < lo) || (f8 > hi);

  assign in_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      last_x       <= '0;
      last_y       <= '0;
      last_time    <= '0;
      window_count <= '0;
      held_speed   <= '0;
      sq_start     <= 1'b0;
      dv_start     <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            dx  <= 21'(in_data.pos_x) - 21'(last_x);
            dy  <= 21'(in_data.pos_y) - 21'(last_y);
            dt  <= in_data.time_us - last_time;
            neg <= (21'(in_data.pos_x) - 21'(last_x)) < 0;
            if (in_data.req_type == REQ_START) begin
              last_x       <= in_data.pos_x;
              last_y       <= in_data.pos_y;
              last_time    <= in_data.time_us;
              window_count <= '0;
              held_speed   <= '0;
              out_data     <= '0;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end else if (in_data.time_us == last_time) begin
              out_data  <= '{held_speed, 1'b0, 1'b0, 1'b1};
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              sq_start <= 1'b1;
              state    <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            dv_start <= 1'b1;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) state <= S_MAG;
        end
        S_MAG: begin
          // Push the signed speed into the window
          last_x    <= cur.pos_x;
          last_y    <= cur.pos_y;
          last_time <= cur.time_us;
          if (window_count >= CW'(WINDOW_DEPTH - 1)) begin
            speed_window[WINDOW_DEPTH-1] <= v;
            for (int i = 0; i < WINDOW_DEPTH; i++)
              srt[i] <= (i == WINDOW_DEPTH - 1) ? v : speed_window[i];
            acc   <= '0;
            step  <= '0;
            state <= S_MUL;
          end else begin
            speed_window[window_count[IW-1:0]] <= v;
            window_count <= window_count + CW'(1);
            held_speed   <= v;
            out_data     <= '{v, 1'b0, 1'b0, 1'b0};
            out_valid    <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_MUL: begin
          acc <= acc + 64'(mul_p);
          step <= step + 2'd1;
          if (step == 2'd2) begin
            sstep <= '0;
            state <= S_SORT;
          end
        end
        S_SORT: begin
          // One odd-even transposition pass per cycle
          for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
            if ((i[0] == sstep[0]) && (srt[i] > srt[i+1])) begin
              srt[i]   <= srt[i+1];
              srt[i+1] <= srt[i];
            end
          end
          sstep <= sstep + 2'd1;
          if (sstep == 2'(WINDOW_DEPTH - 1)) state <= S_SPREAD;
        end
        S_SPREAD: begin
          spread <= 36'(mul_p);
          state  <= S_JUDGE;
        end
        S_JUDGE: begin
          window_count <= CW'(WINDOW_DEPTH - 1);
          if (outl) begin
            held_speed <= speed_window[0];
            out_data   <= '{speed_window[0], 1'b1, 1'b1, 1'b0};
          end else begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
              speed_window[i] <= speed_window[i+1];
            held_speed <= fval;
            out_data   <= '{fval, 1'b1, 1'b0, 1'b0};
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tss_isqrt.sv =====
// Bit-pair square root, one result bit per cycle.
module tss_isqrt
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [57:0] radicand,
  output logic        done,
  output logic [28:0] root
);

  logic [57:0] rem_hi;
  logic [57:0] shreg;
  logic [30:0] acc;
  logic [4:0]  cnt;
  logic        busy;
  logic [30:0] trial;
  logic [30:0] rem_shift;

  assign rem_shift = {acc[28:0], shreg[57:56]};
  assign trial     = {rem_hi[28:0], 2'b01};

  // Advance one bit of root per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        shreg  <= radicand;
        acc    <= '0;
        rem_hi <= '0;
      end else if (busy) begin
        shreg <= {shreg[55:0], 2'b00};
        if (rem_shift >= trial) begin
          acc    <= rem_shift - trial;
          rem_hi <= {rem_hi[56:0], 1'b1};
        end else begin
          acc    <= rem_shift;
          rem_hi <= {rem_hi[56:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd28) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = rem_hi[28:0];

endmodule

// ===== rtl/tss_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module tss_divider
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [48:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [48:0] quotient
);

  logic [48:0] q;
  logic [40:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] rem_shift;
  logic [40:0] diff;

  assign rem_shift = {rem[39:0], q[48]};
  assign diff      = rem_shift - {1'b0, divisor};

  // Shift in one dividend bit and try subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (!diff[40]) begin
          rem <= diff;
          q   <= {q[47:0], 1'b1};
        end else begin
          rem <= rem_shift;
          q   <= {q[47:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

// ===== rtl/tss_checker.sv =====
module tss_checker
  import tss_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input tss_out_t out_data
);

  // Hold stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // No item taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // Close the input after taking an item
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an item");

  // Outlier implies filtered path
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outlier_rejected |-> out_data.window_full)
    else $error("outlier without full window");

  // Bad interval excludes other flags
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_interval |-> !out_data.window_full)
    else $error("bad interval with filtered flag");

endmodule

bind track_speed_smoother_top tss_checker u_tss_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
